>>> src/u8s8dat_pkg.sv
// ----------------------------------------------------------------------------
// u8s8dat_pkg: shared constants for the u8 x s8 dot-accumulate tile
// Field widths, stream packing offsets and parameter defaults used by the
// dot-product unit and the tile core.
// ----------------------------------------------------------------------------
package u8s8dat_pkg;

  // Parameter defaults
  localparam int unsigned TileRowsDef = 8;
  localparam int unsigned LaneColsDef = 8;

  // Field widths
  localparam int unsigned RowW    = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned QuadW   = 4 * ByteW;
  localparam int unsigned MaxCols = 8;
  localparam int unsigned AccW    = 32;
  localparam int unsigned ProdW   = 2 * ByteW + 1;
  localparam int unsigned PairW   = ProdW + 1;
  localparam int unsigned HalfW   = 16;
  localparam int unsigned DotW    = HalfW + 1;

  // Stream packing
  localparam int unsigned InRawW   = RowW + QuadW + MaxCols * QuadW;
  localparam int unsigned InDataW  = ((InRawW + 7) / 8) * 8;
  localparam int unsigned InAOff   = RowW;
  localparam int unsigned InBOff   = RowW + QuadW;
  localparam int unsigned OutRawW  = RowW + MaxCols * AccW;
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8;
  localparam int unsigned OutSOff  = RowW;

endpackage

>>> src/u8s8dat_dot4.sv
// ----------------------------------------------------------------------------
// u8s8dat_dot4: four-deep u8 x s8 dot product with saturated pair sums
// Forms four products, saturates each pair sum to int16 and adds the two
// halves exactly into a 17-bit signed result.
// ----------------------------------------------------------------------------
module u8s8dat_dot4 (
  input  logic [u8s8dat_pkg::QuadW-1:0]       a_quad,  // four unsigned bytes, byte 0 lowest
  input  logic [u8s8dat_pkg::QuadW-1:0]       b_quad,  // four signed bytes, byte 0 lowest
  output logic signed [u8s8dat_pkg::DotW-1:0] dot
);
  import u8s8dat_pkg::*;

  logic signed [ProdW-1:0] prod [4];
  logic signed [PairW-1:0] pair0;
  logic signed [PairW-1:0] pair1;
  logic signed [HalfW-1:0] half0;
  logic signed [HalfW-1:0] half1;

  // Clamp a pair sum to the int16 range.
  function automatic logic signed [HalfW-1:0] sat16(input logic signed [PairW-1:0] v);
    logic signed [HalfW-1:0] r;
    if (v > $signed(PairW'(32767))) begin
      r = 16'sh7FFF;
    end else if (v < -$signed(PairW'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[HalfW-1:0];
    end
    return r;
  endfunction

  // Byte products: the A byte is zero-extended so the multiply stays signed.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = $signed({1'b0, a_quad[ByteW*i +: ByteW]}) * $signed(b_quad[ByteW*i +: ByteW]);
    end
  end

  // Pair sums, saturation and the exact final add.
  always_comb begin
    pair0 = PairW'(prod[0]) + PairW'(prod[1]);
    pair1 = PairW'(prod[2]) + PairW'(prod[3]);
    half0 = sat16(pair0);
    half1 = sat16(pair1);
    dot   = DotW'(half0) + DotW'(half1);
  end

endmodule

>>> src/u8s8_dot_accumulate_tile_core.sv
// Throughput: one request per cycle; the only stall is a finishing in-tile request whose
// result register is still occupied and not being taken downstream.
// Each request passes input register -> dot units and accumulator add; a finishing one then fills the result register.
// Reset (synchronous, active low) clears the row valid flags, so every accumulator reads
// as zero afterward; there is no clearing pass and requests are taken right after reset.
// ----------------------------------------------------------------------------
// u8s8_dot_accumulate_tile_core: u8 x s8 dot-accumulate tile
// Accumulates four-deep dot products into a tile of int32 row accumulators
// and emits a row's column sums when a request marks the row as finished.
// ----------------------------------------------------------------------------
module u8s8_dot_accumulate_tile_core #(
  parameter int unsigned TILE_ROWS    = u8s8dat_pkg::TileRowsDef,
  parameter int unsigned LANE_COLUMNS = u8s8dat_pkg::LaneColsDef
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // row, a_quad, b_col0 .. b_col7, zero pad
  input  logic [u8s8dat_pkg::InDataW-1:0]    in_tdata,
  input  logic                               in_tuser,   // start_row
  input  logic                               in_tlast,   // finish_row
  // Result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_row, sum_col0 .. sum_col7, zero pad
  output logic [u8s8dat_pkg::OutDataW-1:0]   out_tdata
);
  import u8s8dat_pkg::*;

  localparam int unsigned RowIdxW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int unsigned RowExtW = RowIdxW + RowW;

  // Input register
  logic                s1_vld_r;
  logic [RowW-1:0]     s1_row_r;
  logic                s1_start_r;
  logic                s1_finish_r;
  logic [QuadW-1:0]    s1_a_r;
  logic [QuadW-1:0]    s1_b_r [MaxCols];

  // Per-row valid flags
  logic [TILE_ROWS-1:0] row_vld_r;

  // Result register
  logic             out_vld_r;
  logic [RowW-1:0]  out_row_r;
  logic [AccW-1:0]  out_sum_r [MaxCols];

  logic                  out_free;
  logic                  s1_fire;
  logic [RowExtW-1:0]    row_ext;
  logic                  row_hit;
  logic [RowIdxW-1:0]    row_idx;
  logic                  row_fresh;
  logic signed [DotW-1:0] col_dot [MaxCols];
  logic [AccW-1:0]       acc_nxt [MaxCols];

  // Handshake: the input register advances unless a finishing in-tile request waits on
  // an occupied result register.
  assign out_free   = !out_vld_r || out_tready;
  assign s1_fire    = s1_vld_r && (!s1_finish_r || !row_hit || out_free);
  assign in_tready  = !s1_vld_r || s1_fire;
  assign out_tvalid = out_vld_r;

  // Row decode; rows beyond the tile are dropped without effect.
  assign row_ext   = RowExtW'(s1_row_r);
  assign row_hit   = row_ext < RowExtW'(TILE_ROWS);
  assign row_idx   = row_ext[RowIdxW-1:0];
  assign row_fresh = s1_start_r || !row_vld_r[row_idx];

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_row_r    <= in_tdata[RowW-1:0];
      s1_start_r  <= in_tuser;
      s1_finish_r <= in_tlast;
      s1_a_r      <= in_tdata[InAOff +: QuadW];
      for (int c = 0; c < MaxCols; c++) begin
        s1_b_r[c] <= in_tdata[InBOff + QuadW*c +: QuadW];
      end
    end
  end

  // Per-column dot units and accumulator adds
  for (genvar c = 0; c < MaxCols; c++) begin : g_col
    if (c < LANE_COLUMNS) begin : g_used
      // This column's accumulator for every row of the tile.
      logic [AccW-1:0] acc_r [TILE_ROWS];
      logic [AccW-1:0] base;

      u8s8dat_dot4 u_dot4 (
        .a_quad (s1_a_r),
        .b_quad (s1_b_r[c]),
        .dot    (col_dot[c])
      );

      assign base       = row_fresh ? '0 : acc_r[row_idx];
      assign acc_nxt[c] = base + {{(AccW-DotW){col_dot[c][DotW-1]}}, col_dot[c]};

      // Accumulator write for this column
      always_ff @(posedge clk) begin
        if (s1_fire && row_hit) begin
          acc_r[row_idx] <= acc_nxt[c];
        end
      end
    end else begin : g_unused
      assign col_dot[c] = '0;
      assign acc_nxt[c] = '0;
    end
  end

  // Row valid flags: a row reads as zero until its first update after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (s1_fire && row_hit) begin
      row_vld_r[row_idx] <= 1'b1;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire && row_hit && s1_finish_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (s1_fire && row_hit && s1_finish_r) begin
      out_row_r <= s1_row_r;
      for (int c = 0; c < MaxCols; c++) begin
        out_sum_r[c] <= acc_nxt[c];
      end
    end
  end

  // Result packing
  always_comb begin
    out_tdata           = '0;
    out_tdata[RowW-1:0] = out_row_r;
    for (int c = 0; c < MaxCols; c++) begin
      out_tdata[OutSOff + AccW*c +: AccW] = out_sum_r[c];
    end
  end

`ifndef SYNTHESIS
  // A finishing in-tile request shows up as a result for the same row.
  a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && row_hit && s1_finish_r |=> out_vld_r && out_row_r == $past(s1_row_r))
    else $error("finishing request did not produce its result");

  // A result appears only after a finishing in-tile request.
  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_fire && row_hit && s1_finish_r))
    else $error("result appeared without a finishing request");

  // A start-and-finish request reports just its own dot product in column 0.
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && row_hit && s1_finish_r && s1_start_r |=>
      out_sum_r[0] == $past({{(AccW-DotW){col_dot[0][DotW-1]}}, col_dot[0]}))
    else $error("start did not clear the row accumulator");

  // A held request keeps its row while it waits.
  a_hold_row: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_fire |=> s1_vld_r && $stable(s1_row_r))
    else $error("stalled request lost its row");

  // Row valid flags are left unchanged by requests outside the tile.
  a_row_flags: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !row_hit |=> $stable(row_vld_r))
    else $error("out-of-tile request touched the tile");
`endif

endmodule
